@@ hw/rtl/ypco_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypco_pkg
// Shared widths, constants, types and the arctangent table for the
// yaw/pitch camera orientation core.
// ----------------------------------------------------------------------------
package ypco_pkg;

    // default build values of the top-level parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int VEC_FRAC_DEF     = 14;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_TURN_GAIN   = 2'd0,
        REG_PITCH_LIMIT = 2'd1,
        REG_EYE_HEIGHT  = 2'd2,
        REG_FWD_OFFSET  = 2'd3
    } reg_idx_t;

    // field widths
    localparam int TG_W    = 12;
    localparam int PL_W    = 15;
    localparam int EH_W    = 16;
    localparam int FO_W    = 16;
    localparam int MOUSE_W = 12;
    localparam int POS_W   = 32;
    localparam int VEC_W   = 16;
    localparam int YAW_W   = 17;
    localparam int PITCH_W = 16;

    // register reset values
    localparam logic [TG_W-1:0] TG_RST = 12'd733;
    localparam logic [PL_W-1:0] PL_RST = 15'd19200;
    localparam logic [EH_W-1:0] EH_RST = 16'd7475;
    localparam logic [FO_W-1:0] FO_RST = 16'd410;

    // angles in 1/256 degree
    localparam int ANGLE_W       = 18;
    localparam int FULL_TURN     = 92160;
    localparam int QUARTER_TURN  = 23040;
    localparam int HALF_TURN     = 46080;
    localparam int THREE_QUARTER = 69120;

    // CORDIC datapath, Q30 values, angles in 1/65536 degree
    localparam int TRIG_W     = 32;
    localparam int ZW         = 25;
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_W     = 22;
    localparam int STEP_W     = $clog2(ATAN_DEPTH);
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [TRIG_W-1:0] NEG_ONE_Q30 = -32'sd1073741824;

    localparam int PROD_W = 64;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [TG_W-1:0] turn_gain;
        logic [PL_W-1:0] pitch_limit;
        logic [EH_W-1:0] eye_height;
        logic [FO_W-1:0] forward_offset;
    } cfg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_q;
        logic signed [TRIG_W-1:0] cos_q;
    } trig_t;

    typedef struct packed {
        logic signed [POS_W-1:0] eye_x;
        logic signed [POS_W-1:0] eye_y;
        logic signed [POS_W-1:0] eye_z;
        logic signed [VEC_W-1:0] view_x;
        logic signed [VEC_W-1:0] view_y;
        logic signed [VEC_W-1:0] view_z;
        logic signed [VEC_W-1:0] up_x;
        logic signed [VEC_W-1:0] up_y;
        logic signed [VEC_W-1:0] up_z;
        logic signed [VEC_W-1:0] right_x;
        logic signed [VEC_W-1:0] right_y;
        logic signed [VEC_W-1:0] right_z;
    } res_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/ypco_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypco_if
// Valid/ready channels of the camera orientation core: mouse motion with
// player position in, eye position and camera basis vectors out.
// ----------------------------------------------------------------------------
interface ypco_in_if;
    import ypco_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [MOUSE_W-1:0] mouse_dx;
    logic signed [MOUSE_W-1:0] mouse_dy;
    logic signed [POS_W-1:0]   player_x;
    logic signed [POS_W-1:0]   player_y;
    logic signed [POS_W-1:0]   player_z;

    modport source (
        output valid, mouse_dx, mouse_dy, player_x, player_y, player_z,
        input  ready
    );

    modport sink (
        input  valid, mouse_dx, mouse_dy, player_x, player_y, player_z,
        output ready
    );
endinterface

interface ypco_out_if;
    import ypco_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] eye_x;
    logic signed [POS_W-1:0] eye_y;
    logic signed [POS_W-1:0] eye_z;
    logic signed [VEC_W-1:0] view_x;
    logic signed [VEC_W-1:0] view_y;
    logic signed [VEC_W-1:0] view_z;
    logic signed [VEC_W-1:0] up_x;
    logic signed [VEC_W-1:0] up_y;
    logic signed [VEC_W-1:0] up_z;
    logic signed [VEC_W-1:0] right_x;
    logic signed [VEC_W-1:0] right_y;
    logic signed [VEC_W-1:0] right_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, view_x, view_y, view_z,
               up_x, up_y, up_z, right_x, right_y, right_z,
        input  ready
    );

    modport sink (
        input  valid, eye_x, eye_y, eye_z, view_x, view_y, view_z,
               up_x, up_y, up_z, right_x, right_y, right_z,
        output ready
    );
endinterface

@@ hw/rtl/ypco_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypco_regs
// APB-style configuration registers: turn gain, pitch limit, eye height and
// forward offset.
// ----------------------------------------------------------------------------
module ypco_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ypco_pkg::PADDR_W-1:0]   paddr,
    input  logic [ypco_pkg::PDATA_W-1:0]   pwdata,
    output logic [ypco_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output ypco_pkg::cfg_t                 cfg
);
    import ypco_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (idx)
                REG_TURN_GAIN:   cfg_next.turn_gain      = pwdata[TG_W-1:0];
                REG_PITCH_LIMIT: cfg_next.pitch_limit    = pwdata[PL_W-1:0];
                REG_EYE_HEIGHT:  cfg_next.eye_height     = pwdata[EH_W-1:0];
                REG_FWD_OFFSET:  cfg_next.forward_offset = pwdata[FO_W-1:0];
                default:         cfg_next                = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TURN_GAIN:   prdata = PDATA_W'(cfg_reg.turn_gain);
            REG_PITCH_LIMIT: prdata = PDATA_W'(cfg_reg.pitch_limit);
            REG_EYE_HEIGHT:  prdata = PDATA_W'(cfg_reg.eye_height);
            REG_FWD_OFFSET:  prdata = PDATA_W'(cfg_reg.forward_offset);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_gain      <= TG_RST;
            cfg_reg.pitch_limit    <= PL_RST;
            cfg_reg.eye_height     <= EH_RST;
            cfg_reg.forward_offset <= FO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/ypco_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypco_mul
// Shared 32x32 signed multiplier with a registered product; the product
// holds while the enable is low.
// ----------------------------------------------------------------------------
module ypco_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [ypco_pkg::TRIG_W-1:0]  op_a,
    input  logic signed [ypco_pkg::TRIG_W-1:0]  op_b,
    output logic signed [ypco_pkg::PROD_W-1:0]  prod
);
    import ypco_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

endmodule

@@ hw/rtl/ypco_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypco_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle. Reduces the
// angle to the first quadrant and restores the quadrant on the outputs.
// ----------------------------------------------------------------------------
module ypco_cordic #(
    parameter int CORDIC_STEPS = ypco_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [ypco_pkg::ANGLE_W-1:0]  angle,
    output logic                                 done,
    output ypco_pkg::trig_t                      trig
);
    import ypco_pkg::*;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic signed [ANGLE_W-1:0] a_wrap;
    logic signed [ANGLE_W-1:0] a_rem;
    quad_t                     quad;
    quad_t                     quad_reg;
    quad_t                     quad_next;
    logic signed [TRIG_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [TRIG_W-1:0]  dx, dy, xc, yc;
    logic signed [ZW-1:0]      z_reg, z_next, atan_z;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    // only one wrap is needed: yaw is 0..360 deg, pitch within +-128 deg
    always_comb
    begin
        if (angle < 0)
            a_wrap = angle + ANGLE_W'(FULL_TURN);
        else if (angle >= ANGLE_W'(FULL_TURN))
            a_wrap = angle - ANGLE_W'(FULL_TURN);
        else
            a_wrap = angle;

        if (a_wrap >= ANGLE_W'(THREE_QUARTER))
        begin
            quad  = QUAD_270;
            a_rem = a_wrap - ANGLE_W'(THREE_QUARTER);
        end
        else if (a_wrap >= ANGLE_W'(HALF_TURN))
        begin
            quad  = QUAD_180;
            a_rem = a_wrap - ANGLE_W'(HALF_TURN);
        end
        else if (a_wrap >= ANGLE_W'(QUARTER_TURN))
        begin
            quad  = QUAD_90;
            a_rem = a_wrap - ANGLE_W'(QUARTER_TURN);
        end
        else
        begin
            quad  = QUAD_0;
            a_rem = a_wrap;
        end
    end

    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_z = ZW'(atan_lut(step_reg));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = ZW'(a_rem) <<< 8;
            quad_next = quad;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ZW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_z;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_z;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        xc = (x_reg > ONE_Q30) ? ONE_Q30 : ((x_reg < NEG_ONE_Q30) ? NEG_ONE_Q30 : x_reg);
        yc = (y_reg > ONE_Q30) ? ONE_Q30 : ((y_reg < NEG_ONE_Q30) ? NEG_ONE_Q30 : y_reg);
        case (quad_reg)
            QUAD_0:
            begin
                trig.sin_q = yc;
                trig.cos_q = xc;
            end
            QUAD_90:
            begin
                trig.sin_q = xc;
                trig.cos_q = -yc;
            end
            QUAD_180:
            begin
                trig.sin_q = -yc;
                trig.cos_q = -xc;
            end
            default:
            begin
                trig.sin_q = -xc;
                trig.cos_q = yc;
            end
        endcase
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
    end

endmodule

@@ hw/rtl/yaw_pitch_camera_orientation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pitch_camera_orientation_core
// First-person camera: accumulates yaw and pitch from mouse motion, places
// the eye and builds the view, up and right vectors.
//
//   channel   dir   handshake          contents
//   motion    in    valid/ready        mouse_dx/dy, player_x/y/z
//   camera    out   valid/ready        eye_x/y/z, view, up, right vectors
//   apb       in    psel/penable       turn_gain, pitch_limit, eye_height,
//                                      forward_offset at 0x0/0x4/0x8/0xC
//
// Each transaction passes through the single CORDIC unit, run for yaw,
// then pitch; the next one is accepted only once its result is loaded
// into the output register and the core has returned to idle.
// Multiplies go one at a time through one shared 32x32 multiplier.
// motion.ready is high only in idle; a finished result waits in the output
// register while the next transaction is taken in and worked on.
// Reset: yaw and pitch zero, previous view (0, 0, 1), registers to defaults.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_orientation_core #(
    parameter int CORDIC_STEPS     = ypco_pkg::CORDIC_STEPS_DEF,
    parameter int VECTOR_FRAC_BITS = ypco_pkg::VEC_FRAC_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ypco_pkg::PADDR_W-1:0]   paddr,
    input  logic [ypco_pkg::PDATA_W-1:0]   pwdata,
    output logic [ypco_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    ypco_in_if.sink                        motion,
    ypco_out_if.source                     camera
);
    import ypco_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DX,
        ST_MUL_DY,
        ST_MUL_FX,
        ST_MUL_FZ,
        ST_EYE,
        ST_COR_YAW,
        ST_COR_PITCH,
        ST_MUL_V0,
        ST_MUL_V2,
        ST_MUL_V3,
        ST_MUL_V5,
        ST_OUT
    } state_t;

    localparam int GPROD_W   = 26;  // turn_gain * mouse count
    localparam int YSUM_W    = 19;
    localparam int PSUM_W    = 27;
    localparam int OFF_W     = 34;
    localparam int ESUM_W    = 35;
    localparam int LV_W      = VEC_W + 1;  // holds +1.0 at 15 fraction bits
    localparam int QF        = 30 - VECTOR_FRAC_BITS;
    localparam int PF        = 60 - VECTOR_FRAC_BITS;

    localparam logic signed [PROD_W-1:0] VEC_ONE  = PROD_W'(1) <<< VECTOR_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] VEC_MAX  = 64'sd32767;
    localparam logic signed [PROD_W-1:0] VEC_MIN  = -64'sd32768;
    localparam logic signed [PROD_W-1:0] HALF_P   = PROD_W'(1) <<< (PF - 1);
    localparam logic signed [PROD_W-1:0] HALF_Q   = PROD_W'(1) <<< (QF - 1);
    localparam logic signed [OFF_W-1:0]  EYE_HALF = OFF_W'(1) <<< (VECTOR_FRAC_BITS - 1);

    // clamp to +-1.0, then to the 16-bit range
    function automatic logic signed [VEC_W-1:0] to_vec(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] c;
        c = v;
        if (c > VEC_ONE)
            c = VEC_ONE;
        else if (c < -VEC_ONE)
            c = -VEC_ONE;
        if (c > VEC_MAX)
            c = VEC_MAX;
        else if (c < VEC_MIN)
            c = VEC_MIN;
        return c[VEC_W-1:0];
    endfunction

    function automatic logic signed [VEC_W-1:0] vec_q60(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        r = (v + HALF_P) >>> PF;
        return to_vec(r);
    endfunction

    function automatic logic signed [VEC_W-1:0] vec_q30(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        r = (v + HALF_Q) >>> QF;
        return to_vec(r);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ESUM_W-1:0] s);
        logic signed [ESUM_W-1:0] c;
        c = s;
        if (c > ESUM_W'(POS_MAX))
            c = ESUM_W'(POS_MAX);
        else if (c < ESUM_W'(POS_MIN))
            c = ESUM_W'(POS_MIN);
        return c[POS_W-1:0];
    endfunction

    cfg_t                       cfg;
    trig_t                      trig;
    logic                       cor_start;
    logic                       cor_done;
    logic signed [ANGLE_W-1:0]  cor_angle;

    logic                       mul_en;
    logic signed [TRIG_W-1:0]   mul_a;
    logic signed [TRIG_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   prod;

    state_t                     state_reg, state_next;
    logic [YAW_W-1:0]           yaw_reg, yaw_next;
    logic signed [PITCH_W-1:0]  pitch_reg, pitch_next;
    logic signed [LV_W-1:0]     lv_x_reg, lv_x_next, lv_z_reg, lv_z_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [MOUSE_W-1:0]  dx_reg, dy_reg;
    logic signed [POS_W-1:0]    px_reg, py_reg, pz_reg;
    logic signed [POS_W-1:0]    eye_x_reg, eye_y_reg, eye_z_reg;
    logic signed [TRIG_W-1:0]   sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [VEC_W-1:0]    v0_reg, v2_reg, v3_reg;
    res_t                       res_reg;

    logic                       accept;
    logic                       load_out;
    logic signed [GPROD_W-1:0]  gprod;
    logic signed [YSUM_W-1:0]   yaw_step, yaw_sum, yaw_wrap;
    logic signed [PSUM_W-1:0]   pitch_sum, lim_s;
    logic signed [OFF_W-1:0]    off_full, eye_off;
    logic signed [ESUM_W-1:0]   eye_sum, eh_s, eye_y_sum;
    logic signed [POS_W-1:0]    eye_base;
    logic signed [VEC_W-1:0]    vec_prod;

    ypco_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ypco_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    ypco_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (cor_angle),
        .done  (cor_done),
        .trig  (trig)
    );

    assign motion.ready = (state_reg == ST_IDLE);
    assign accept       = motion.valid && (state_reg == ST_IDLE);
    assign load_out     = (state_reg == ST_OUT) && (!out_valid_reg || camera.ready);

    // yaw runs first, pitch starts on the cycle yaw completes
    assign cor_start = (state_reg == ST_EYE) || ((state_reg == ST_COR_YAW) && cor_done);
    assign cor_angle = (state_reg == ST_EYE) ? ANGLE_W'($signed({1'b0, yaw_reg}))
                                             : ANGLE_W'(pitch_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_DX:
            begin
                mul_a = TRIG_W'(cfg.turn_gain);
                mul_b = TRIG_W'(dx_reg);
            end
            ST_MUL_DY:
            begin
                mul_a = TRIG_W'(cfg.turn_gain);
                mul_b = TRIG_W'(dy_reg);
            end
            ST_MUL_FX:
            begin
                mul_a = TRIG_W'(cfg.forward_offset);
                mul_b = TRIG_W'(lv_x_reg);
            end
            ST_MUL_FZ:
            begin
                mul_a = TRIG_W'(cfg.forward_offset);
                mul_b = TRIG_W'(lv_z_reg);
            end
            ST_MUL_V0:
            begin
                mul_a = cp_reg;
                mul_b = sy_reg;
            end
            ST_MUL_V2:
            begin
                mul_a = cp_reg;
                mul_b = cy_reg;
            end
            ST_MUL_V3:
            begin
                mul_a = -sp_reg;
                mul_b = sy_reg;
            end
            ST_MUL_V5:
            begin
                mul_a = -sp_reg;
                mul_b = cy_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // yaw: clamp the step to one turn, wrap once (exactly 360 deg is kept)
    always_comb
    begin
        gprod = prod[GPROD_W-1:0];
        if (gprod > GPROD_W'(FULL_TURN))
            yaw_step = YSUM_W'(FULL_TURN);
        else if (gprod < GPROD_W'(-FULL_TURN))
            yaw_step = YSUM_W'(-FULL_TURN);
        else
            yaw_step = YSUM_W'(gprod);
        yaw_sum = YSUM_W'($signed({1'b0, yaw_reg})) + yaw_step;
        if (yaw_sum > YSUM_W'(FULL_TURN))
            yaw_wrap = yaw_sum - YSUM_W'(FULL_TURN);
        else if (yaw_sum < 0)
            yaw_wrap = yaw_sum + YSUM_W'(FULL_TURN);
        else
            yaw_wrap = yaw_sum;
    end

    assign pitch_sum = PSUM_W'(pitch_reg) + PSUM_W'(gprod);
    assign lim_s     = PSUM_W'(cfg.pitch_limit);

    // eye offset along the previous view, x then z through the same adder
    assign off_full  = OFF_W'(prod);
    assign eye_off   = (off_full + EYE_HALF) >>> VECTOR_FRAC_BITS;
    assign eye_base  = (state_reg == ST_MUL_FZ) ? px_reg : pz_reg;
    assign eye_sum   = ESUM_W'(eye_base) + ESUM_W'(eye_off);
    assign eh_s      = ESUM_W'(cfg.eye_height);
    assign eye_y_sum = ESUM_W'(py_reg) + eh_s;

    assign vec_prod  = vec_q60(prod);

    always_comb
    begin
        state_next     = state_reg;
        yaw_next       = yaw_reg;
        pitch_next     = pitch_reg;
        lv_x_next      = lv_x_reg;
        lv_z_next      = lv_z_reg;
        out_valid_next = out_valid_reg;
        if (camera.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (motion.valid)
                    state_next = ST_MUL_DX;
            end
            ST_MUL_DX:
            begin
                state_next = ST_MUL_DY;
            end
            ST_MUL_DY:
            begin
                yaw_next   = yaw_wrap[YAW_W-1:0];
                state_next = ST_MUL_FX;
            end
            ST_MUL_FX:
            begin
                // a move that would pass the limit leaves pitch unchanged
                if ((pitch_sum <= lim_s) && (pitch_sum >= -lim_s))
                    pitch_next = pitch_sum[PITCH_W-1:0];
                state_next = ST_MUL_FZ;
            end
            ST_MUL_FZ:
            begin
                state_next = ST_EYE;
            end
            ST_EYE:
            begin
                state_next = ST_COR_YAW;
            end
            ST_COR_YAW:
            begin
                if (cor_done)
                    state_next = ST_COR_PITCH;
            end
            ST_COR_PITCH:
            begin
                if (cor_done)
                    state_next = ST_MUL_V0;
            end
            ST_MUL_V0:
            begin
                state_next = ST_MUL_V2;
            end
            ST_MUL_V2:
            begin
                state_next = ST_MUL_V3;
            end
            ST_MUL_V3:
            begin
                state_next = ST_MUL_V5;
            end
            ST_MUL_V5:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    lv_x_next      = LV_W'(v0_reg);
                    lv_z_next      = LV_W'(v2_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            lv_x_reg      <= '0;
            lv_z_reg      <= LV_W'(VEC_ONE);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            yaw_reg       <= yaw_next;
            pitch_reg     <= pitch_next;
            lv_x_reg      <= lv_x_next;
            lv_z_reg      <= lv_z_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= motion.mouse_dx;
            dy_reg <= motion.mouse_dy;
            px_reg <= motion.player_x;
            py_reg <= motion.player_y;
            pz_reg <= motion.player_z;
        end
        if (state_reg == ST_MUL_FZ)
            eye_x_reg <= sat_pos(eye_sum);
        if (state_reg == ST_EYE)
        begin
            eye_z_reg <= sat_pos(eye_sum);
            eye_y_reg <= sat_pos(eye_y_sum);
        end
        if ((state_reg == ST_COR_YAW) && cor_done)
        begin
            sy_reg <= trig.sin_q;
            cy_reg <= trig.cos_q;
        end
        if ((state_reg == ST_COR_PITCH) && cor_done)
        begin
            sp_reg <= trig.sin_q;
            cp_reg <= trig.cos_q;
        end
        if (state_reg == ST_MUL_V2)
            v0_reg <= vec_prod;
        if (state_reg == ST_MUL_V3)
            v2_reg <= vec_prod;
        if (state_reg == ST_MUL_V5)
            v3_reg <= vec_prod;
        if (load_out)
        begin
            res_reg.eye_x   <= eye_x_reg;
            res_reg.eye_y   <= eye_y_reg;
            res_reg.eye_z   <= eye_z_reg;
            res_reg.view_x  <= v0_reg;
            res_reg.view_y  <= vec_q30(PROD_W'(sp_reg));
            res_reg.view_z  <= v2_reg;
            res_reg.up_x    <= v3_reg;
            res_reg.up_y    <= vec_q30(PROD_W'(cp_reg));
            res_reg.up_z    <= vec_prod;
            res_reg.right_x <= vec_q30(-PROD_W'(cy_reg));
            res_reg.right_y <= '0;
            res_reg.right_z <= vec_q30(PROD_W'(sy_reg));
        end
    end

    assign camera.valid   = out_valid_reg;
    assign camera.eye_x   = res_reg.eye_x;
    assign camera.eye_y   = res_reg.eye_y;
    assign camera.eye_z   = res_reg.eye_z;
    assign camera.view_x  = res_reg.view_x;
    assign camera.view_y  = res_reg.view_y;
    assign camera.view_z  = res_reg.view_z;
    assign camera.up_x    = res_reg.up_x;
    assign camera.up_y    = res_reg.up_y;
    assign camera.up_z    = res_reg.up_z;
    assign camera.right_x = res_reg.right_x;
    assign camera.right_y = res_reg.right_y;
    assign camera.right_z = res_reg.right_z;

endmodule

@@ sim/tb_yaw_pitch_camera_orientation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yaw_pitch_camera_orientation_core
// Drives mouse/position transactions into the camera orientation core,
// programs its registers over APB between phases, and checks every camera
// result against an in-bench fixed-point model of yaw/pitch accumulation,
// eye placement and CORDIC-based basis vectors. Directed cases come first,
// then random phases under several register settings with random idling.
// ----------------------------------------------------------------------------
module tb_yaw_pitch_camera_orientation_core;
    import ypco_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 110;
    localparam int FRAC           = VEC_FRAC_DEF;
    localparam int PROD_SHIFT     = 60 - FRAC;
    localparam int Q30_SHIFT      = 30 - FRAC;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ypco_in_if  motion_ch ();
    ypco_out_if camera_ch ();

    yaw_pitch_camera_orientation_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .motion  (motion_ch),
        .camera  (camera_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // model state and register copies
    longint yaw_angle    = 0;
    longint pitch_angle  = 0;
    longint prev_view[3] = '{0, 0, 64'sd1 << FRAC};
    longint gain_cfg     = TG_RST;
    longint limit_cfg    = PL_RST;
    longint height_cfg   = EH_RST;
    longint offset_cfg   = FO_RST;

    // atan(2^-i) in 1/65536 degree
    longint arctan_tab[0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    res_t camera_expected[$];
    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    int   stall_left     = 0;
    bit   idling_on      = 1'b1;

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint to_vec(longint v);
        longint one;
        one = 64'sd1 << FRAC;
        return clamp64(clamp64(v, -one, one), -32768, 32767);
    endfunction

    function automatic void sin_cos_of(input longint ang, output longint s,
                                       output longint c);
        longint a, quad, z, x, y, t, dx, dy, sr, cr;
        int     i;
        a = ang % FULL_TURN;
        if (a < 0)
            a += FULL_TURN;
        quad = a / QUARTER_TURN;
        z    = (a - quad * QUARTER_TURN) * 256;
        x    = longint'(CORDIC_GAIN);
        y    = 0;
        for (i = 0; i < CORDIC_STEPS_DEF && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                t = x - dx;
                y = y + dy;
                z -= arctan_tab[i];
            end
            else
            begin
                t = x + dx;
                y = y - dy;
                z += arctan_tab[i];
            end
            x = t;
        end
        cr = clamp64(x, longint'(NEG_ONE_Q30), longint'(ONE_Q30));
        sr = clamp64(y, longint'(NEG_ONE_Q30), longint'(ONE_Q30));
        // restore quadrant by swap/negate
        case (quad)
            0:       begin s = sr;  c = cr;  end
            1:       begin s = cr;  c = -sr; end
            2:       begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr;  end
        endcase
    endfunction

    function automatic res_t compute_camera(logic [MOUSE_W-1:0] dx, logic [MOUSE_W-1:0] dy,
                                            logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                            logic [POS_W-1:0] pz);
        longint step, new_yaw, new_pitch, sy, cy, sp, cp, ex, ey, ez;
        longint vx, vy, vz;
        res_t   r;
        step    = clamp64(gain_cfg * longint'($signed(dx)), -FULL_TURN, FULL_TURN);
        new_yaw = yaw_angle + step;
        if (new_yaw > FULL_TURN)
            new_yaw -= FULL_TURN;
        else if (new_yaw < 0)
            new_yaw += FULL_TURN;
        yaw_angle = new_yaw;

        // pitch move rejected whole if it leaves the window
        new_pitch = pitch_angle + gain_cfg * longint'($signed(dy));
        if (new_pitch <= limit_cfg && new_pitch >= -limit_cfg)
            pitch_angle = new_pitch;

        ex = clamp64(longint'($signed(px)) + round_shift(offset_cfg * prev_view[0], FRAC),
                     POS_MIN, POS_MAX);
        ey = clamp64(longint'($signed(py)) + height_cfg, POS_MIN, POS_MAX);
        ez = clamp64(longint'($signed(pz)) + round_shift(offset_cfg * prev_view[2], FRAC),
                     POS_MIN, POS_MAX);

        sin_cos_of(yaw_angle, sy, cy);
        sin_cos_of(pitch_angle, sp, cp);

        vx = to_vec(round_shift(cp * sy, PROD_SHIFT));
        vy = to_vec(round_shift(sp, Q30_SHIFT));
        vz = to_vec(round_shift(cp * cy, PROD_SHIFT));

        r.eye_x   = ex[POS_W-1:0];
        r.eye_y   = ey[POS_W-1:0];
        r.eye_z   = ez[POS_W-1:0];
        r.view_x  = vx[VEC_W-1:0];
        r.view_y  = vy[VEC_W-1:0];
        r.view_z  = vz[VEC_W-1:0];
        r.up_x    = to_vec(round_shift(-(sp * sy), PROD_SHIFT));
        r.up_y    = to_vec(round_shift(cp, Q30_SHIFT));
        r.up_z    = to_vec(round_shift(-(sp * cy), PROD_SHIFT));
        r.right_x = to_vec(round_shift(-cy, Q30_SHIFT));
        r.right_y = '0;
        r.right_z = to_vec(round_shift(sy, Q30_SHIFT));

        prev_view[0] = vx;
        prev_view[1] = vy;
        prev_view[2] = vz;
        return r;
    endfunction

    function automatic void apply_reg(reg_idx_t idx, logic [PDATA_W-1:0] data);
        case (idx)
            REG_TURN_GAIN:   gain_cfg   = data[TG_W-1:0];
            REG_PITCH_LIMIT: limit_cfg  = data[PL_W-1:0];
            REG_EYE_HEIGHT:  height_cfg = data[EH_W-1:0];
            REG_FWD_OFFSET:  offset_cfg = data[FO_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d (0x%h) expected %0d (0x%h)",
                                      name, $signed(got), got, $signed(want), want));
    endtask

    task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        apply_reg(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop sending, wait for all results, then let the core settle
    task automatic drain_pipeline();
        @(negedge clk);
        motion_ch.valid <= 1'b0;
        while (camera_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_camera_config(logic [PDATA_W-1:0] gain, logic [PDATA_W-1:0] limit,
                                     logic [PDATA_W-1:0] height,
                                     logic [PDATA_W-1:0] offset);
        drain_pipeline();
        write_reg(REG_TURN_GAIN, gain);
        write_reg(REG_PITCH_LIMIT, limit);
        write_reg(REG_EYE_HEIGHT, height);
        write_reg(REG_FWD_OFFSET, offset);
    endtask

    task automatic send_motion(logic [MOUSE_W-1:0] dx, logic [MOUSE_W-1:0] dy,
                               logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                               logic [POS_W-1:0] pz);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            motion_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        motion_ch.valid    <= 1'b1;
        motion_ch.mouse_dx <= dx;
        motion_ch.mouse_dy <= dy;
        motion_ch.player_x <= px;
        motion_ch.player_y <= py;
        motion_ch.player_z <= pz;
        do @(posedge clk); while (!motion_ch.ready);
        camera_expected.push_back(compute_camera(dx, dy, px, py, pz));
    endtask

    function automatic logic [MOUSE_W-1:0] rand_mouse(int mode);
        if (mode < 12)
            return MOUSE_W'($urandom_range(0, 128) - 64);
        if (mode < 16)
            return MOUSE_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return -2048;
            1:       return 2047;
            2:       return -1;
            3:       return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_position();
        if ($urandom_range(0, 5) != 0)
            return $urandom;
        if ($urandom_range(0, 1) == 0)
            return 32'h7FFF_FFFF - $urandom_range(0, 70000);
        return 32'h8000_0000 + $urandom_range(0, 70000);
    endfunction

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_motion(0, 0, 0, 0, 0);
    endtask

    task automatic test_yaw_wrap();
        send_motion(2047, 0, 100, 200, 300);    // clamped step lands on 360 exactly
        send_motion(0, 0, 100, 200, 300);
        send_motion(-2048, 0, -5, -6, -7);      // clamped negative step back to 0
        send_motion(-1, 0, 1, 2, 3);            // wrap below zero
        send_motion(1, 0, 1, 2, 3);             // back to exactly 360
        send_motion(2, 0, 1, 2, 3);             // wrap above 360
    endtask

    task automatic test_pitch_limit();
        send_motion(0, 26, 0, 0, 0);            // just inside the default limit
        send_motion(0, 1, 0, 0, 0);             // would pass it: held
        send_motion(0, 2047, 0, 0, 0);
        set_camera_config(TG_RST, 10000, EH_RST, FO_RST);
        send_motion(0, 0, 0, 0, 0);             // beyond the lowered limit: stays
        send_motion(0, -5, 0, 0, 0);            // still beyond: stays
        send_motion(0, -13, 0, 0, 0);           // lands inside
        send_motion(0, -2048, 0, 0, 0);
        send_motion(0, -26, 0, 0, 0);
        set_camera_config(TG_RST, 32'h0000_7FFF, EH_RST, FO_RST);  // above stated range
        send_motion(5, 30, 0, 0, 0);
        send_motion(5, 27, 0, 0, 0);            // pitch past 90 degrees
    endtask

    task automatic test_eye_saturation();
        set_camera_config(TG_RST, PL_RST, 32'h0000_FFFF, 32'h0000_FFFF);
        send_motion(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_motion(63, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_motion(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_motion(-31, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    task automatic test_register_extremes();
        set_camera_config(0, 0, 0, 0);
        send_motion(2047, -2048, 0, 0, 0);
        send_motion(-2048, 2047, -1, -1, -1);
        set_camera_config(32'hFFFF_FFFF, 0, 32'h0000_FFFF, 0);
        send_motion(-2048, 1, 32'h0000_1234, 32'h7FFF_0000, 32'h8000_0001);
        send_motion(2047, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    endtask

    // ------------------------------------------------------------------
    // random phases under varied register settings
    // ------------------------------------------------------------------
    task automatic test_random_phases();
        int phase, n, mode;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_camera_config(1, QUARTER_TURN, 0, 32'h0000_FFFF);
                1: set_camera_config(32'h0000_0FFF, 0, 32'h0000_FFFF, 0);
                2: set_camera_config($urandom, $urandom, $urandom, $urandom);
                3: set_camera_config($urandom_range(0, 400), $urandom_range(0, QUARTER_TURN),
                                     $urandom, $urandom);
                default: set_camera_config(TG_RST, PL_RST, EH_RST, FO_RST);
            endcase
            idling_on = (phase != RANDOM_PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                mode = $urandom_range(0, 19);
                send_motion(rand_mouse(mode), rand_mouse((mode >= 18) ? 0 : mode),
                            rand_position(), rand_position(), rand_position());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result sink: random backpressure bursts
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (idling_on && stall_left > 0)
        begin
            camera_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            camera_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end
        else
            camera_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && camera_ch.valid && camera_ch.ready)
        begin
            if (camera_expected.size() == 0)
                report_mismatch("camera transaction with no pending expectation");
            else
            begin
                want = camera_expected.pop_front();
                check_field("eye_x",   camera_ch.eye_x,   want.eye_x);
                check_field("eye_y",   camera_ch.eye_y,   want.eye_y);
                check_field("eye_z",   camera_ch.eye_z,   want.eye_z);
                check_field("view_x",  camera_ch.view_x,  want.view_x);
                check_field("view_y",  camera_ch.view_y,  want.view_y);
                check_field("view_z",  camera_ch.view_z,  want.view_z);
                check_field("up_x",    camera_ch.up_x,    want.up_x);
                check_field("up_y",    camera_ch.up_y,    want.up_y);
                check_field("up_z",    camera_ch.up_z,    want.up_z);
                check_field("right_x", camera_ch.right_x, want.right_x);
                check_field("right_y", camera_ch.right_y, want.right_y);
                check_field("right_z", camera_ch.right_z, want.right_z);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((motion_ch.valid && motion_ch.ready) || (camera_ch.valid && camera_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        motion_ch.valid    = 1'b0;
        motion_ch.mouse_dx = '0;
        motion_ch.mouse_dy = '0;
        motion_ch.player_x = '0;
        motion_ch.player_y = '0;
        motion_ch.player_z = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_yaw_wrap();
        test_pitch_limit();
        test_eye_saturation();
        test_register_extremes();
        test_random_phases();
        drain_pipeline();

        if (mismatch_count == 0 && camera_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ yaw_pitch_camera_orientation_core.f @@
hw/rtl/ypco_pkg.sv
hw/rtl/ypco_if.sv
hw/rtl/ypco_regs.sv
hw/rtl/ypco_mul.sv
hw/rtl/ypco_cordic.sv
hw/rtl/yaw_pitch_camera_orientation_core.sv
sim/tb_yaw_pitch_camera_orientation_core.sv
